### rtl/directional_index_tracker_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the directional index tracker
// Immediate-implication and next-cycle checks on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef DIRECTIONAL_INDEX_TRACKER_MACROS_SVH
`define DIRECTIONAL_INDEX_TRACKER_MACROS_SVH
`ifndef SYNTHESIS
`define DIT_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dit check failed");
`define DIT_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dit check failed");
`else
`define DIT_ASSERT_IMP(label, ante, cons)
`define DIT_ASSERT_NXT(label, ante, cons)
`endif
`endif

### rtl/dit_pkg.sv
// ----------------------------------------------------------------------------
// dit_pkg
// Shared widths, constants and controller/datapath link types.
// ----------------------------------------------------------------------------
package dit_pkg;

    localparam int SMOOTH_BITS = 48;
    localparam int ACC_BITS    = 28;
    localparam int DX_BITS     = 23;
    localparam int ADX_BITS    = 23;
    localparam int DIV_DIGITS  = 6;
    localparam int SMALL_STEPS = SMOOTH_BITS / DIV_DIGITS;
    localparam int DX_STEPS    = DX_BITS;
    localparam int STEP_BITS   = 5;

    localparam logic [ADX_BITS-1:0] ADX_DEFAULT = 23'd655360;

    typedef struct packed {
        logic capture;
        logic move;
        logic div_step;
        logic smooth_update;
        logic dx_load;
        logic dx_step;
        logic take;
        logic acc_store;
        logic out_load;
    } dit_cmd_t;

    typedef struct packed {
        logic moves;
        logic move_full;
        logic dx_ok;
        logic dx_full;
        logic dx_last;
    } dit_sts_t;

endpackage

### rtl/dit_if.sv
// ----------------------------------------------------------------------------
// dit channel interfaces
// Price bar input channel and ADX result channel, valid/ready transfer.
// ----------------------------------------------------------------------------
interface dit_bar_if;
    logic        valid;
    logic        ready;
    logic        first_of_series;
    logic [31:0] high_price;
    logic [31:0] low_price;
    logic [31:0] close_price;

    modport source (output valid, first_of_series, high_price, low_price, close_price,
                    input ready);
    modport sink (input valid, first_of_series, high_price, low_price, close_price,
                  output ready);
endinterface

interface dit_adx_if;
    logic        valid;
    logic        ready;
    logic [22:0] adx_value;
    logic        adx_valid;

    modport source (output valid, adx_value, adx_valid, input ready);
    modport sink (input valid, adx_value, adx_valid, output ready);
endinterface

### rtl/dit_pdiv.sv
// ----------------------------------------------------------------------------
// dit_pdiv
// Serial divide by PERIOD, DIV_DIGITS quotient bits per step.
// ----------------------------------------------------------------------------
module dit_pdiv
    import dit_pkg::*;
#(
    parameter int PERIOD = 14
)
(
    input  logic                   clk,
    input  logic                   load,
    input  logic                   step,
    input  logic [SMOOTH_BITS-1:0] dividend,
    output logic [SMOOTH_BITS-1:0] quotient
);

    localparam int RW = $clog2(PERIOD);

    logic [SMOOTH_BITS-1:0] num_reg;
    logic [SMOOTH_BITS-1:0] num_next;
    logic [RW-1:0]          rem_reg;
    logic [RW-1:0]          rem_next;

    always_comb
    begin
        logic [RW:0] trial;
        num_next = num_reg;
        rem_next = rem_reg;
        for (int i = 0; i < DIV_DIGITS; i++)
        begin
            trial    = {rem_next, num_next[SMOOTH_BITS-1]};
            num_next = {num_next[SMOOTH_BITS-2:0], 1'b0};
            if (trial >= (RW+1)'(PERIOD))
            begin
                trial       = trial - (RW+1)'(PERIOD);
                num_next[0] = 1'b1;
            end
            rem_next = trial[RW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            num_reg <= dividend;
            rem_reg <= '0;
        end
        else if (step)
        begin
            num_reg <= num_next;
            rem_reg <= rem_next;
        end
    end

    assign quotient = num_reg;

endmodule

### rtl/dit_datapath.sv
// ----------------------------------------------------------------------------
// dit_datapath
// Bar history, directional moves, Wilder smoothing, DX divider and ADX state.
// ----------------------------------------------------------------------------
module dit_datapath
    import dit_pkg::*;
#(
    parameter int PERIOD     = 14,
    parameter int PRICE_BITS = 32
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  dit_cmd_t            cmd,
    output dit_sts_t            sts,
    input  logic                first_of_series,
    input  logic [31:0]         high_price,
    input  logic [31:0]         low_price,
    input  logic [31:0]         close_price,
    output logic [ADX_BITS-1:0] adx_value,
    output logic                adx_valid
);

    localparam int PW = (PRICE_BITS < 32) ? PRICE_BITS : 32;
    localparam int CW = $clog2(PERIOD + 1);
    localparam int SW = SMOOTH_BITS;
    localparam int PRODW = ACC_BITS + 6;

    logic          first_reg;
    logic [PW-1:0] h_reg, l_reg, c_reg;
    logic          have_prev_reg;
    logic [PW-1:0] ph_reg, pl_reg, pc_reg;
    logic [PW-1:0] pdm_reg, ndm_reg, tr_reg;
    logic [CW-1:0] move_count_reg, dx_count_reg;
    logic [SW-1:0] sp_reg, sm_reg, st_reg;
    logic [ACC_BITS-1:0] acc_reg;
    logic [SW:0]         den_reg, rem_reg;
    logic [DX_BITS-1:0]  nq_reg;
    logic [ADX_BITS-1:0] adx_value_reg;
    logic                adx_valid_reg;

    logic signed [PW:0] up, down, hl;
    logic [PW-1:0]      pdm, ndm, t2, t3, mx23, tr;
    logic [SW-1:0]      qp, qm, qt, gap;
    logic [SW:0]        sum;
    logic [SW+6:0]      d100;
    logic [SW+1:0]      trial;
    logic [ACC_BITS-1:0] acc_sum;
    logic [PRODW-1:0]    prod;
    logic [SW-1:0]       lane0_in;
    logic                lane_load;
    logic                move_full, dx_full;

    // directional moves and true range
    always_comb
    begin
        up   = $signed({1'b0, h_reg}) - $signed({1'b0, ph_reg});
        down = $signed({1'b0, pl_reg}) - $signed({1'b0, l_reg});
        hl   = $signed({1'b0, h_reg}) - $signed({1'b0, l_reg});
        pdm  = (up > down && up > 0) ? up[PW-1:0] : '0;
        ndm  = (down > up && down > 0) ? down[PW-1:0] : '0;
        t2   = (h_reg >= pc_reg) ? h_reg - pc_reg : pc_reg - h_reg;
        t3   = (l_reg >= pc_reg) ? l_reg - pc_reg : pc_reg - l_reg;
        mx23 = (t3 > t2) ? t3 : t2;
        tr   = (hl > $signed({1'b0, mx23})) ? hl[PW-1:0] : mx23;
    end

    assign move_full = (move_count_reg == CW'(PERIOD));
    assign dx_full   = (dx_count_reg == CW'(PERIOD));
    assign sum       = {1'b0, sp_reg} + {1'b0, sm_reg};
    assign gap       = (sp_reg > sm_reg) ? sp_reg - sm_reg : sm_reg - sp_reg;
    assign d100      = {1'b0, gap, 6'b0} + {2'b0, gap, 5'b0} + {5'b0, gap, 2'b0};
    assign trial     = {rem_reg, nq_reg[DX_BITS-1]};
    assign acc_sum   = acc_reg + ACC_BITS'(nq_reg);
    assign prod      = PRODW'(acc_reg) * PRODW'(PERIOD - 1) + PRODW'(nq_reg);
    assign lane0_in  = cmd.take ? (dx_full ? SW'(prod) : SW'(acc_sum)) : sp_reg;
    assign lane_load = cmd.move | cmd.take;

    dit_pdiv #(.PERIOD(PERIOD)) u_div_plus (
        .clk(clk), .load(lane_load), .step(cmd.div_step), .dividend(lane0_in), .quotient(qp)
    );
    dit_pdiv #(.PERIOD(PERIOD)) u_div_minus (
        .clk(clk), .load(lane_load), .step(cmd.div_step), .dividend(sm_reg), .quotient(qm)
    );
    dit_pdiv #(.PERIOD(PERIOD)) u_div_range (
        .clk(clk), .load(lane_load), .step(cmd.div_step), .dividend(st_reg), .quotient(qt)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            first_reg <= first_of_series;
            h_reg     <= high_price[PW-1:0];
            l_reg     <= low_price[PW-1:0];
            c_reg     <= close_price[PW-1:0];
        end
        if (cmd.move)
        begin
            pdm_reg <= pdm;
            ndm_reg <= ndm;
            tr_reg  <= tr;
        end
        if (cmd.dx_load)
        begin
            den_reg <= sum;
            rem_reg <= (SW+1)'(d100[SW+6:7]);
            nq_reg  <= {d100[6:0], 16'b0};
        end
        else if (cmd.dx_step)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_reg <= (SW+1)'(trial - {1'b0, den_reg});
                nq_reg  <= {nq_reg[DX_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial[SW:0];
                nq_reg  <= {nq_reg[DX_BITS-2:0], 1'b0};
            end
        end
        if (cmd.out_load)
        begin
            adx_value_reg <= dx_full ? acc_reg[ADX_BITS-1:0] : ADX_DEFAULT;
            adx_valid_reg <= dx_full;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_prev_reg  <= 1'b0;
            ph_reg         <= '0;
            pl_reg         <= '0;
            pc_reg         <= '0;
            move_count_reg <= '0;
            dx_count_reg   <= '0;
            sp_reg         <= '0;
            sm_reg         <= '0;
            st_reg         <= '0;
            acc_reg        <= '0;
        end
        else
        begin
            if (cmd.move)
            begin
                if (first_reg)
                begin
                    move_count_reg <= '0;
                    dx_count_reg   <= '0;
                    sp_reg         <= '0;
                    sm_reg         <= '0;
                    st_reg         <= '0;
                    acc_reg        <= '0;
                end
                have_prev_reg <= 1'b1;
                ph_reg        <= h_reg;
                pl_reg        <= l_reg;
                pc_reg        <= c_reg;
            end
            if (cmd.smooth_update)
            begin
                if (move_full)
                begin
                    sp_reg <= sp_reg - qp + SW'(pdm_reg);
                    sm_reg <= sm_reg - qm + SW'(ndm_reg);
                    st_reg <= st_reg - qt + SW'(tr_reg);
                end
                else
                begin
                    sp_reg         <= sp_reg + SW'(pdm_reg);
                    sm_reg         <= sm_reg + SW'(ndm_reg);
                    st_reg         <= st_reg + SW'(tr_reg);
                    move_count_reg <= move_count_reg + 1'b1;
                end
            end
            if (cmd.take && !dx_full)
            begin
                acc_reg      <= acc_sum;
                dx_count_reg <= dx_count_reg + 1'b1;
            end
            if (cmd.acc_store)
            begin
                acc_reg <= qp[ACC_BITS-1:0];
            end
        end
    end

    assign sts.moves     = have_prev_reg && !first_reg;
    assign sts.move_full = move_full;
    assign sts.dx_ok     = (st_reg != '0) && (sum != '0);
    assign sts.dx_full   = dx_full;
    assign sts.dx_last   = (dx_count_reg == CW'(PERIOD - 1));

    assign adx_value = adx_value_reg;
    assign adx_valid = adx_valid_reg;

endmodule

### rtl/dit_ctrl.sv
// ----------------------------------------------------------------------------
// dit_ctrl
// Sequencer for one bar: moves, smoothing, DX division, ADX update, result.
// ----------------------------------------------------------------------------
`include "directional_index_tracker_macros.svh"

module dit_ctrl
    import dit_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    input  dit_sts_t sts,
    output dit_cmd_t cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_MOVE   = 4'd1;
    localparam logic [3:0] S_SDIV   = 4'd2;
    localparam logic [3:0] S_SUPD   = 4'd3;
    localparam logic [3:0] S_CHECK  = 4'd4;
    localparam logic [3:0] S_DXDIV  = 4'd5;
    localparam logic [3:0] S_TAKE   = 4'd6;
    localparam logic [3:0] S_ADIV   = 4'd7;
    localparam logic [3:0] S_ASTORE = 4'd8;
    localparam logic [3:0] S_FINISH = 4'd9;

    logic [3:0]           state_reg, state_next;
    logic [STEP_BITS-1:0] cnt_reg, cnt_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 out_free;

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg + 1'b1;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                cmd.capture = in_valid;
                if (in_valid)
                    state_next = S_MOVE;
            end
            S_MOVE:
            begin
                cmd.move = 1'b1;
                cnt_next = '0;
                if (!sts.moves)
                    state_next = S_FINISH;
                else if (sts.move_full)
                    state_next = S_SDIV;
                else
                    state_next = S_SUPD;
            end
            S_SDIV:
            begin
                cmd.div_step = 1'b1;
                if (cnt_reg == STEP_BITS'(SMALL_STEPS - 1))
                    state_next = S_SUPD;
            end
            S_SUPD:
            begin
                cmd.smooth_update = 1'b1;
                state_next        = S_CHECK;
            end
            S_CHECK:
            begin
                cnt_next = '0;
                if (sts.move_full && sts.dx_ok)
                begin
                    cmd.dx_load = 1'b1;
                    state_next  = S_DXDIV;
                end
                else
                    state_next = S_FINISH;
            end
            S_DXDIV:
            begin
                cmd.dx_step = 1'b1;
                if (cnt_reg == STEP_BITS'(DX_STEPS - 1))
                    state_next = S_TAKE;
            end
            S_TAKE:
            begin
                cmd.take = 1'b1;
                cnt_next = '0;
                state_next = (sts.dx_full || sts.dx_last) ? S_ADIV : S_FINISH;
            end
            S_ADIV:
            begin
                cmd.div_step = 1'b1;
                if (cnt_reg == STEP_BITS'(SMALL_STEPS - 1))
                    state_next = S_ASTORE;
            end
            S_ASTORE:
            begin
                cmd.acc_store = 1'b1;
                state_next    = S_FINISH;
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    // result register never overwritten while a transfer is pending
    `DIT_ASSERT_IMP(a_no_overwrite, cmd.out_load, !out_valid_reg || out_ready)
    `DIT_ASSERT_NXT(a_accept_to_move, in_valid && in_ready, state_reg == S_MOVE)
    `DIT_ASSERT_NXT(a_dx_done, state_reg == S_DXDIV && cnt_reg == STEP_BITS'(DX_STEPS - 1),
                    state_reg == S_TAKE)
    `DIT_ASSERT_IMP(a_dx_needs_full, cmd.dx_load, sts.move_full)

endmodule

### rtl/directional_index_tracker.sv
// A bar that forms no moves passes from S_MOVE straight to S_FINISH; a bar that
// runs the smoothing divide, the DX divide and the ADX divide passes S_SDIV,
// S_SUPD, S_CHECK, S_DXDIV, S_TAKE, S_ADIV and S_ASTORE first; one bar in flight.
// The DX long division, one quotient bit per cycle, is the longest of the divides.
// Reset (rst_n, asynchronous, active low) clears the bar history and out_valid.
// ----------------------------------------------------------------------------
// directional_index_tracker
// Wilder ADX over a stream of price bars, one result per bar.
// ----------------------------------------------------------------------------
module directional_index_tracker
    import dit_pkg::*;
#(
    parameter int PERIOD     = 14,
    parameter int PRICE_BITS = 32
)
(
    input  logic      clk,
    input  logic      rst_n,
    dit_bar_if.sink   bar,
    dit_adx_if.source adx
);

    dit_cmd_t cmd;
    dit_sts_t sts;

    dit_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (bar.valid),
        .in_ready  (bar.ready),
        .out_valid (adx.valid),
        .out_ready (adx.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    dit_datapath #(
        .PERIOD     (PERIOD),
        .PRICE_BITS (PRICE_BITS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .first_of_series (bar.first_of_series),
        .high_price      (bar.high_price),
        .low_price       (bar.low_price),
        .close_price     (bar.close_price),
        .adx_value       (adx.adx_value),
        .adx_valid       (adx.adx_valid)
    );

endmodule

### sim/directional_index_tracker_checker.sv
// ----------------------------------------------------------------------------
// directional_index_tracker_checker
// Watches the bar and ADX channels, predicts the Wilder ADX for every bar
// transfer and compares each result transfer against the oldest prediction.
// ----------------------------------------------------------------------------
module directional_index_tracker_checker
    import dit_pkg::*;
#(
    parameter int PERIOD = 14
)
(
    input  logic      clk,
    input  logic      rst_n,
    dit_bar_if.sink   bar,
    dit_adx_if.sink   adx,
    output int        fail_count,
    output int        pending_count,
    output int        bar_count,
    output int        valid_seen
);

    typedef struct packed {
        logic [ADX_BITS-1:0] value;
        logic                valid;
    } adx_result_t;

    adx_result_t adx_queue[$];

    logic                   have_prev;
    logic [31:0]            prev_high;
    logic [31:0]            prev_low;
    logic [31:0]            prev_close;
    int                     move_cnt;
    logic [SMOOTH_BITS-1:0] sm_plus;
    logic [SMOOTH_BITS-1:0] sm_minus;
    logic [SMOOTH_BITS-1:0] sm_range;
    int                     dx_cnt;
    logic [ACC_BITS-1:0]    adx_acc;

    function automatic logic [63:0] dx_percent(logic [63:0] num, logic [63:0] den);
        logic [63:0] scaled;
        logic [63:0] q;
        logic [63:0] r;
        scaled = num * 64'd100;
        q = scaled / den;
        r = scaled % den;
        for (int i = 0; i < 16; i++)
        begin
            r = r << 1;
            q = q << 1;
            if (r >= den)
            begin
                r = r - den;
                q[0] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic [SMOOTH_BITS-1:0] wilder_step(logic [SMOOTH_BITS-1:0] s,
                                                          logic [63:0] m);
        return s - s / PERIOD + m[SMOOTH_BITS-1:0];
    endfunction

    task automatic clear_series();
        have_prev  = 1'b0;
        prev_high  = '0;
        prev_low   = '0;
        prev_close = '0;
        move_cnt   = 0;
        sm_plus    = '0;
        sm_minus   = '0;
        sm_range   = '0;
        dx_cnt     = 0;
        adx_acc    = '0;
    endtask

    task automatic predict_bar(logic first, logic [31:0] h, logic [31:0] l,
                               logic [31:0] c);
        longint      up;
        longint      down;
        longint      tr;
        longint      t2;
        longint      t3;
        logic [63:0] pdm;
        logic [63:0] ndm;
        logic [63:0] p;
        logic [63:0] m;
        logic [63:0] dx;
        logic [63:0] acc;
        logic        ready;
        adx_result_t res;
        if (first)
            clear_series();
        if (have_prev)
        begin
            up   = longint'(h) - longint'(prev_high);
            down = longint'(prev_low) - longint'(l);
            pdm  = (up > down && up > 0) ? 64'(up) : 64'd0;
            ndm  = (down > up && down > 0) ? 64'(down) : 64'd0;
            tr   = longint'(h) - longint'(l);
            t2   = longint'(h) - longint'(prev_close);
            t3   = longint'(l) - longint'(prev_close);
            if (t2 < 0) t2 = -t2;
            if (t3 < 0) t3 = -t3;
            if (t2 > tr) tr = t2;
            if (t3 > tr) tr = t3;
            if (move_cnt < PERIOD)
            begin
                sm_plus  = sm_plus + pdm[SMOOTH_BITS-1:0];
                sm_minus = sm_minus + ndm[SMOOTH_BITS-1:0];
                sm_range = sm_range + SMOOTH_BITS'(tr);
                move_cnt++;
                ready = (move_cnt == PERIOD);
            end
            else
            begin
                sm_plus  = wilder_step(sm_plus, pdm);
                sm_minus = wilder_step(sm_minus, ndm);
                sm_range = wilder_step(sm_range, 64'(tr));
                ready = 1'b1;
            end
            p = 64'(sm_plus);
            m = 64'(sm_minus);
            if (ready && sm_range != 0 && (p + m) != 0)
            begin
                dx = dx_percent(p > m ? p - m : m - p, p + m);
                if (dx_cnt < PERIOD)
                begin
                    adx_acc = adx_acc + dx[ACC_BITS-1:0];
                    dx_cnt++;
                    if (dx_cnt == PERIOD)
                        adx_acc = adx_acc / PERIOD;
                end
                else
                begin
                    acc = (64'(adx_acc) * (PERIOD - 1) + dx) / PERIOD;
                    adx_acc = acc[ACC_BITS-1:0];
                end
            end
        end
        have_prev  = 1'b1;
        prev_high  = h;
        prev_low   = l;
        prev_close = c;
        if (dx_cnt >= PERIOD)
        begin
            res.value = adx_acc[ADX_BITS-1:0];
            res.valid = 1'b1;
        end
        else
        begin
            res.value = ADX_DEFAULT;
            res.valid = 1'b0;
        end
        adx_queue.insert(adx_queue.size(), res);
    endtask

    initial
    begin
        fail_count    = 0;
        pending_count = 0;
        bar_count     = 0;
        valid_seen    = 0;
        clear_series();
    end

    always @(posedge clk)
    begin
        adx_result_t want;
        if (rst_n)
        begin
            if (adx.valid && adx.ready)
            begin
                if (adx_queue.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result transfer: value %0d valid %0d",
                                 adx.adx_value, adx.adx_valid);
                end
                else
                begin
                    want = adx_queue.pop_front();
                    if (adx.adx_valid)
                        valid_seen++;
                    if (want.value !== adx.adx_value || want.valid !== adx.adx_valid)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: expected %0d/%0d, got %0d/%0d",
                                     want.value, want.valid, adx.adx_value,
                                     adx.adx_valid);
                    end
                end
            end
            if (bar.valid && bar.ready)
            begin
                predict_bar(bar.first_of_series, bar.high_price, bar.low_price,
                            bar.close_price);
                bar_count++;
            end
            pending_count = adx_queue.size();
        end
    end

endmodule

### sim/directional_index_tracker_test.sv
// ----------------------------------------------------------------------------
// directional_index_tracker_test
// Drives price bar series into the ADX tracker with bursty input and a
// stalling receiver; a checker module predicts and compares every result.
// ----------------------------------------------------------------------------
module directional_index_tracker_test;

    localparam int PERIOD      = 14;
    localparam int WATCH_LIMIT = 20000;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending_count;
    int   bar_count;
    int   valid_seen;
    int   idle_cycles;
    int   hold_off;
    logic stall_done;
    int   series_cnt;

    dit_bar_if bar ();
    dit_adx_if adx ();

    directional_index_tracker #(.PERIOD(PERIOD), .PRICE_BITS(32)) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .bar   (bar.sink),
        .adx   (adx.source)
    );

    directional_index_tracker_checker #(.PERIOD(PERIOD)) u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .bar           (bar.sink),
        .adx           (adx.sink),
        .fail_count    (fail_count),
        .pending_count (pending_count),
        .bar_count     (bar_count),
        .valid_seen    (valid_seen)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    // receiver: random stalls with calm stretches, and one long hold-off after 300 bars
    initial
    begin
        adx.ready  = 1'b0;
        hold_off   = 0;
        stall_done = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (bar_count >= 300 && !stall_done)
            begin
                adx.ready <= 1'b0;
                hold_off++;
                if (hold_off >= 400)
                    stall_done = 1'b1;
            end
            else if ((bar_count / 64) % 3 == 1)
                adx.ready <= 1'b1;
            else
                adx.ready <= ($urandom_range(0, 3) != 0);
        end
    end

    initial
    begin
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && !((bar.valid && bar.ready) || (adx.valid && adx.ready)))
                idle_cycles++;
            else
                idle_cycles = 0;
            if (idle_cycles >= WATCH_LIMIT)
            begin
                $display("[directional_index_tracker] ERROR");
                $finish;
            end
        end
    end

    task automatic send_bar(logic first, logic [31:0] h, logic [31:0] l, logic [31:0] c);
        bar.valid           <= 1'b1;
        bar.first_of_series <= first;
        bar.high_price      <= h;
        bar.low_price       <= l;
        bar.close_price     <= c;
        @(posedge clk);
        while (!bar.ready)
            @(posedge clk);
    endtask

    task automatic pause_sender(int cycles);
        bar.valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic drain();
        bar.valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    // random walk series; mostly well-formed bars, some wild
    task automatic random_series(int length, int spread);
        logic [31:0] base;
        logic [31:0] h;
        logic [31:0] l;
        logic [31:0] c;
        int          burst;
        base = $urandom;
        burst = $urandom_range(1, 12);
        for (int i = 0; i < length; i++)
        begin
            if ($urandom_range(0, 15) == 0)
            begin
                h = $urandom;
                l = $urandom;
                c = $urandom;
            end
            else
            begin
                base = base + $urandom_range(0, 2 * spread) - spread;
                h = base + $urandom_range(0, spread);
                l = base - $urandom_range(0, spread);
                c = l + $urandom_range(0, spread);
                if ($urandom_range(0, 20) == 0)
                    h = l;
            end
            send_bar(i == 0 || $urandom_range(0, 200) == 0, h, l, c);
            burst--;
            if (burst == 0)
            begin
                burst = $urandom_range(1, 12);
                if ($urandom_range(0, 2) != 0)
                    pause_sender($urandom_range(1, 40));
            end
        end
    endtask

    initial
    begin
        bar.valid           = 1'b0;
        bar.first_of_series = 1'b0;
        bar.high_price      = '0;
        bar.low_price       = '0;
        bar.close_price     = '0;
        series_cnt          = 0;
        rst_n               = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, flat bars, low above high, equal moves
        send_bar(1'b1, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF);
        send_bar(1'b0, 32'h0, 32'hFFFF_FFFF, 32'h0);
        send_bar(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000);
        send_bar(1'b1, 32'd100, 32'd100, 32'd100);
        for (int i = 0; i < 16; i++)
            send_bar(1'b0, 32'd100, 32'd100, 32'd100);
        send_bar(1'b0, 32'd110, 32'd90, 32'd100);
        send_bar(1'b0, 32'd50, 32'd200, 32'd60);
        send_bar(1'b0, 32'hAAAA_5555, 32'h5555_AAAA, 32'h1234_5678);
        drain();

        // random-walk series of 5 to 80 bars, some long enough to make ADX valid
        while (bar_count < 700)
        begin
            random_series($urandom_range(5, 80),
                          (series_cnt % 4 == 0) ? 3 : $urandom_range(4, 1 << 20));
            series_cnt++;
            if (series_cnt % 5 == 0)
                drain();
        end
        drain();
        pause_sender(0);

        $display("bars sent: %0d in %0d series, valid ADX results seen: %0d",
                 bar_count, series_cnt, valid_seen);
        if (fail_count == 0)
            $display("[directional_index_tracker] OK");
        else
            $display("[directional_index_tracker] ERROR");
        $finish;
    end

endmodule
